### hw/rtl/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg
// shared types, constants and the angle quantiser for the non-maximum
// suppression block
// ----------------------------------------------------------------------------
`default_nettype none

package cnms_pkg;

  // default line length limit of the column memory
  localparam int MAX_WIDTH_DEF = 1024;

  // frame geometry limits and reset values
  localparam logic [10:0] DIM_MIN        = 11'd3;
  localparam logic [10:0] HEIGHT_MAX     = 11'd1024;
  localparam logic [10:0] WIDTH_RST      = 11'd640;
  localparam logic [10:0] HEIGHT_RST     = 11'd480;
  localparam int          REG_LIMIT      = 2047;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // row counter saturation value
  localparam logic [10:0] ROW_SAT = 11'h7ff;

  // quantised gradient direction
  typedef enum logic [1:0] {
    SEC_HORIZ     = 2'd0,  // left / right
    SEC_DIAG_DOWN = 2'd1,  // up-left / down-right
    SEC_VERT      = 2'd2,  // up / down
    SEC_DIAG_UP   = 2'd3   // up-right / down-left
  } sector_t;

  // one stored pixel: sector in bits 9..8, magnitude in bits 7..0
  typedef struct packed {
    sector_t    sector;
    logic [7:0] mag;
  } cell_t;

  // pixel and position information handed from the front end to the window
  typedef struct packed {
    cell_t pix;
    logic  emit;    // this transaction releases a result
    logic  eof;     // released pixel is the last of the frame
    logic  eor;     // released pixel is the last of its row
    logic  top;     // released pixel lies in the first row
    logic  bot;     // released pixel lies in the last row
    logic  left;    // released pixel lies in the first column
    logic  up_ok;   // upper line entry holds a pixel of this frame
    logic  mid_ok;  // middle line entry holds a pixel of this frame
  } pix_info_t;

  // sector bounds in Q2.13, matching pi/8, 3pi/8, 5pi/8, 7pi/8
  localparam logic signed [15:0] POS_B1 = 16'sd3217;
  localparam logic signed [15:0] POS_B2 = 16'sd9651;
  localparam logic signed [15:0] POS_B3 = 16'sd16085;
  localparam logic signed [15:0] POS_B4 = 16'sd22519;
  localparam logic signed [15:0] NEG_B1 = -16'sd22518;
  localparam logic signed [15:0] NEG_B2 = -16'sd16084;
  localparam logic signed [15:0] NEG_B3 = -16'sd9650;
  localparam logic signed [15:0] NEG_B4 = -16'sd3216;

  function automatic sector_t sector_of(input logic signed [15:0] a);
    sector_t s;
    if (!a[15]) begin
      if (a < POS_B1)      s = SEC_HORIZ;
      else if (a < POS_B2) s = SEC_DIAG_DOWN;
      else if (a < POS_B3) s = SEC_VERT;
      else if (a < POS_B4) s = SEC_DIAG_UP;
      else                 s = SEC_HORIZ;
    end else begin
      if (a < NEG_B1)      s = SEC_HORIZ;
      else if (a < NEG_B2) s = SEC_DIAG_DOWN;
      else if (a < NEG_B3) s = SEC_VERT;
      else if (a < NEG_B4) s = SEC_DIAG_UP;
      else                 s = SEC_HORIZ;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cnms_ram.sv
// ----------------------------------------------------------------------------
// cnms_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cnms_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = cnms_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cnms_front.sv
// ----------------------------------------------------------------------------
// cnms_front
// raster position counters, angle quantiser and release decode for each
// accepted pixel
// ----------------------------------------------------------------------------
`default_nettype none

module cnms_front #(
  parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         restart,
  input  wire logic                         accept,
  input  wire logic [10:0]                  frame_width,
  input  wire logic [10:0]                  frame_height,
  input  wire logic                         kind,
  input  wire logic [7:0]                   magnitude,
  input  wire logic signed [15:0]           angle,
  output      logic [$clog2(MAX_WIDTH)-1:0] col,
  output      cnms_pkg::pix_info_t          info
);
  import cnms_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [10:0]      row;
  logic [10:0]      row_next;
  logic [COL_W-1:0] col_next;
  logic [12:0]      col_inc;
  logic             col_nz;
  logic [10:0]      prow;
  cell_t            pix;

  assign col_nz  = (col != '0);
  assign col_inc = 13'(col) + 13'd1;
  assign prow    = col_nz ? (row - 11'd1) : (row - 11'd2);

  always_comb begin
    pix = '0;
    if (kind == KIND_PIXEL && row < frame_height) begin
      pix.sector = sector_of(angle);
      pix.mag    = magnitude;
    end
  end

  always_comb begin
    info        = '0;
    info.pix    = pix;
    info.up_ok  = (row >= 11'd2);
    info.mid_ok = (row >= 11'd1);
    info.emit   = (row >= 11'd2) || (row == 11'd1 && col_nz);
    // the item at column zero releases the last pixel of a row, two rows above it
    info.eor    = info.emit && !col_nz;
    info.left   = col_nz && (col == COL_W'(1));
    info.top    = (prow == 11'd0);
    info.bot    = (prow >= frame_height - 11'd1);
    info.eof    = info.eor && (prow == frame_height - 11'd1);
  end

  always_comb begin
    row_next = row;
    col_next = col;
    if (restart) begin
      row_next = '0;
      col_next = '0;
    end else if (accept) begin
      if (info.eof) begin
        row_next = '0;
        col_next = '0;
      end else if (col_inc >= 13'(frame_width)) begin
        col_next = '0;
        row_next = (row == ROW_SAT) ? row : row + 11'd1;
      end else begin
        col_next = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cnms_window.sv
// ----------------------------------------------------------------------------
// cnms_window
// line memory write-back, 3x3 window and local maximum test with the result
// register
// ----------------------------------------------------------------------------
`default_nettype none

module cnms_window #(
  parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         restart,
  input  wire logic                         in_load,
  output      logic                         in_ready,
  input  wire cnms_pkg::pix_info_t          in_info,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] in_col,
  input  wire logic [19:0]                  mem_rdata,
  output      logic                         mem_we,
  output      logic [$clog2(MAX_WIDTH)-1:0] mem_waddr,
  output      logic [19:0]                  mem_wdata,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [7:0]                   out_suppressed,
  output      logic                         out_eor,
  output      logic                         out_eof
);
  import cnms_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic             s1_valid;
  pix_info_t        s1_info;
  logic [COL_W-1:0] s1_col;
  logic             out_free;
  logic             s1_go;
  cell_t            up_cell;
  cell_t            mid_cell;
  cell_t            win     [3][3];
  cell_t            win_nxt [3][3];
  cell_t            centre;
  logic [7:0]       nb_a;
  logic [7:0]       nb_b;
  logic [7:0]       nb_max;
  logic [7:0]       result;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!s1_info.emit || out_free);
  assign in_ready = !s1_valid || s1_go;

  // upper half of the memory word is the upper line, lower half the middle
  assign up_cell  = s1_info.up_ok  ? cell_t'(mem_rdata[19:10]) : '0;
  assign mid_cell = s1_info.mid_ok ? cell_t'(mem_rdata[9:0])   : '0;

  // middle line moves up, new pixel becomes the middle line
  assign mem_we    = s1_go;
  assign mem_waddr = s1_col;
  assign mem_wdata = {mem_rdata[9:0], s1_info.pix};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win[r][1];
      win_nxt[r][1] = win[r][2];
    end
    win_nxt[0][2] = up_cell;
    win_nxt[1][2] = mid_cell;
    win_nxt[2][2] = s1_info.pix;
  end

  assign centre = win_nxt[1][1];

  // neighbours along the gradient, outside the frame read as zero
  always_comb begin
    unique case (centre.sector)
      SEC_HORIZ: begin
        nb_a = s1_info.left ? 8'd0 : win_nxt[1][0].mag;
        nb_b = s1_info.eor  ? 8'd0 : win_nxt[1][2].mag;
      end
      SEC_DIAG_DOWN: begin
        nb_a = (s1_info.top || s1_info.left) ? 8'd0 : win_nxt[0][0].mag;
        nb_b = (s1_info.bot || s1_info.eor)  ? 8'd0 : win_nxt[2][2].mag;
      end
      SEC_VERT: begin
        nb_a = s1_info.top ? 8'd0 : win_nxt[0][1].mag;
        nb_b = s1_info.bot ? 8'd0 : win_nxt[2][1].mag;
      end
      SEC_DIAG_UP: begin
        nb_a = (s1_info.top || s1_info.eor)  ? 8'd0 : win_nxt[0][2].mag;
        nb_b = (s1_info.bot || s1_info.left) ? 8'd0 : win_nxt[2][0].mag;
      end
      default: begin
        nb_a = 8'd0;
        nb_b = 8'd0;
      end
    endcase
  end

  assign nb_max = (nb_a > nb_b) ? nb_a : nb_b;
  assign result = (centre.mag < nb_max) ? 8'd0 : centre.mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_load) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_info <= in_info;
      s1_col  <= in_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart || (s1_go && s1_info.eof)) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_go) begin
      win <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_info.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_info.emit) begin
      out_suppressed <= result;
      out_eor        <= s1_info.eor;
      out_eof        <= s1_info.eof;
    end
  end

  // a held result is never overwritten by a new one
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && s1_valid && s1_info.emit) |-> !mem_we)
    else $error("result register overrun");

  // the window restarts after the last pixel of a frame
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_info.eof) |=> (win[1][1] == '0 && win[1][2] == '0 && win[2][2] == '0))
    else $error("window not cleared at frame end");

  // the last pixel of a frame closes its row
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_eof) |-> out_eor)
    else $error("frame end without row end");

  // a pixel is only taken while the stage can pass its occupant on
  assert property (@(posedge clk) disable iff (rst)
    (in_load && s1_valid) |-> s1_go)
    else $error("stage one overwritten");

endmodule

`default_nettype wire

### hw/rtl/canny_nonmax_suppression.sv
// pipeline: the releasing input is held in stage one, its result in the output register;
//   pixel (r,c) is released by the input at (r+1,c+1), so the stream is delayed by width+1 items
// throughput: one item per cycle unless stalled, as the line ram has one read and one write port
// reset: clears position counters, window, pipeline valids and sets width 640, height 480;
//   the line ram is not cleared, entries are always written in a frame before they are used
// ----------------------------------------------------------------------------
// canny_nonmax_suppression
// four-direction non-maximum suppression on a raster stream of gradient
// magnitude and angle, with a two-line store and a 3x3 window
// ----------------------------------------------------------------------------
`default_nettype none

module canny_nonmax_suppression #(
  parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input pixel stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // magnitude [7:0], angle [23:8]
  input  wire logic        s_axis_tuser,   // kind
  // suppressed magnitude stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // suppressed [7:0]
  output      logic        m_axis_tlast,   // end_of_row
  output      logic        m_axis_tuser,   // end_of_frame
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import cnms_pkg::*;

  localparam int          COL_W  = $clog2(MAX_WIDTH);
  // widest usable row: the line ram depth, bounded by the register width
  localparam logic [10:0] WIDTH_MAX = 11'((MAX_WIDTH < REG_LIMIT) ? MAX_WIDTH : REG_LIMIT);

  logic             cfg_write;
  logic [10:0]      wr_value;
  logic [10:0]      frame_width;
  logic [10:0]      frame_height;
  logic             accept;
  logic [COL_W-1:0] col;
  pix_info_t        info;
  logic [19:0]      mem_rdata;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  logic [19:0]      mem_wdata;

  // ---- configuration registers ----

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign wr_value  = pwdata[10:0];
  assign prdata    = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(frame_height) : 32'(frame_width);

  // written values are clamped into the supported geometry, the reset width too
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= (WIDTH_RST > WIDTH_MAX) ? WIDTH_MAX : WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        frame_width <= (wr_value < DIM_MIN)   ? DIM_MIN :
                       (wr_value > WIDTH_MAX) ? WIDTH_MAX : wr_value;
      end else begin
        frame_height <= (wr_value < DIM_MIN)    ? DIM_MIN :
                        (wr_value > HEIGHT_MAX) ? HEIGHT_MAX : wr_value;
      end
    end
  end

  // ---- front end: position tracking and angle quantiser ----

  assign accept = s_axis_tvalid && s_axis_tready;

  cnms_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_write),
    .accept       (accept),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .kind         (s_axis_tuser),
    .magnitude    (s_axis_tdata[7:0]),
    .angle        (s_axis_tdata[23:8]),
    .col          (col),
    .info         (info)
  );

  // ---- line ram: one word per column holds upper and middle line ----
  // the column is read on acceptance and written back one stage later;
  // consecutive transactions address different columns within a frame

  cnms_ram #(
    .WIDTH (20),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (mem_rdata)
  );

  // ---- window, local maximum test and result register ----

  cnms_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .restart        (cfg_write),
    .in_load        (accept),
    .in_ready       (s_axis_tready),
    .in_info        (info),
    .in_col         (col),
    .mem_rdata      (mem_rdata),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_suppressed (m_axis_tdata),
    .out_eor        (m_axis_tlast),
    .out_eof        (m_axis_tuser)
  );

endmodule

`default_nettype wire

### dv/tb_canny_nonmax_suppression.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_canny_nonmax_suppression
// self-checking bench for the four-direction non-maximum suppression block:
// drives pixel and flush transactions plus register writes, predicts every
// suppressed pixel with its own line stores and 3x3 window, and compares
// each output transaction in order under random and held back-pressure
// ----------------------------------------------------------------------------

module tb_canny_nonmax_suppression;

  import cnms_pkg::*;

  // register byte addresses, index times four
  localparam logic [2:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

  // sector edges in Q2.13, compared exactly as the real bounds
  localparam int ANG_P1 = 3217;
  localparam int ANG_P2 = 9651;
  localparam int ANG_P3 = 16085;
  localparam int ANG_P4 = 22519;
  localparam int ANG_N1 = -22518;
  localparam int ANG_N2 = -16084;
  localparam int ANG_N3 = -9650;
  localparam int ANG_N4 = -3216;

  localparam int LINE_DEPTH   = MAX_WIDTH_DEF;
  localparam int DIM_LOW      = 3;
  localparam int DIM_HIGH     = 1024;
  localparam int DRAIN_CYCLES = 16;    // settling margin after the last expected pixel
  localparam int QUIET_LIMIT  = 4000;  // longest legal silence is the HOLD_CYCLES sink hold
  localparam int HOLD_CYCLES  = 600;

  // one suppressed pixel as it leaves the block
  typedef struct packed {
    logic [7:0] mag;
    logic       eor;
    logic       eof;
  } nms_result_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata  = '0;   // magnitude [7:0], angle [23:8]
  logic        s_axis_tuser  = 1'b0; // kind
  logic        m_axis_tready = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;

  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [7:0]  m_axis_tdata;         // suppressed [7:0]
  wire         m_axis_tlast;         // end_of_row
  wire         m_axis_tuser;         // end_of_frame
  wire  [31:0] prdata;
  wire         pready;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  canny_nonmax_suppression i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------------
  int send_idle_pct = 0;   // chance per cycle that the pixel source holds back
  int recv_idle_pct = 0;   // chance per cycle that the sink drops tready
  int hold_request  = 0;   // long sink stall asked for by a test
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int fail_count    = 0;

  nms_result_t expected_pixels[$];

  // predictor copy of the geometry registers and frame position
  int   frame_w = 640;
  int   frame_h = 480;
  int   col_pos = 0;
  int   row_pos = 0;
  cell_t upper_line [LINE_DEPTH];
  cell_t middle_line [LINE_DEPTH];
  cell_t win [3][3];

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic sector_t angle_sector(input logic signed [15:0] a);
    int v;
    v = a;
    if (v >= 0) begin
      if (v < ANG_P1) return SEC_HORIZ;
      if (v < ANG_P2) return SEC_DIAG_DOWN;
      if (v < ANG_P3) return SEC_VERT;
      if (v < ANG_P4) return SEC_DIAG_UP;
      return SEC_HORIZ;  // beyond 7pi/8 wraps back to horizontal
    end
    if (v < ANG_N1) return SEC_HORIZ;  // also covers angles below -pi
    if (v < ANG_N2) return SEC_DIAG_DOWN;
    if (v < ANG_N3) return SEC_VERT;
    if (v < ANG_N4) return SEC_DIAG_UP;
    return SEC_HORIZ;
  endfunction

  // only the low 11 bits of a write are held, then clamped into range
  function automatic int clamp_dim(input logic [10:0] raw);
    int v;
    v = raw;
    if (v < DIM_LOW) return DIM_LOW;
    if (v > DIM_HIGH) return DIM_HIGH;
    return v;
  endfunction

  task automatic restart_frame();
    int r, c;
    col_pos = 0;
    row_pos = 0;
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        win[r][c] = '0;
  endtask

  // one accepted input transaction: shift the lines and window, and queue the
  // centre pixel it releases, if any
  task automatic predict_pixel(input logic kind, input logic [7:0] mag,
                               input logic signed [15:0] ang);
    cell_t       cur, up, mid;
    int          pr, pc, r, c;
    logic [7:0]  nb [3][3];
    logic [7:0]  a, b, peak, centre;
    logic        emit, last_px;
    nms_result_t res;
    cur = '0;
    up  = '0;
    mid = '0;
    // flush items and anything past the last row enter as zero pixels
    if (kind == KIND_PIXEL && row_pos < frame_h) begin
      cur.sector = angle_sector(ang);
      cur.mag    = mag;
    end
    if (row_pos >= 2) up = upper_line[col_pos];
    if (row_pos >= 1) mid = middle_line[col_pos];
    upper_line[col_pos]  = middle_line[col_pos];
    middle_line[col_pos] = cur;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = cur;

    emit    = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
    last_px = 1'b0;
    if (emit) begin
      pr = (col_pos >= 1) ? row_pos - 1 : row_pos - 2;
      pc = (col_pos >= 1) ? col_pos - 1 : frame_w - 1;
      // neighbours outside the frame read as zero
      for (r = 0; r < 3; r++)
        for (c = 0; c < 3; c++)
          nb[r][c] = ((r == 0 && pr == 0) || (r == 2 && pr >= frame_h - 1) ||
                      (c == 0 && pc == 0) || (c == 2 && pc >= frame_w - 1)) ?
                     8'd0 : win[r][c].mag;
      case (win[1][1].sector)
        SEC_HORIZ:     begin a = nb[1][0]; b = nb[1][2]; end
        SEC_DIAG_DOWN: begin a = nb[0][0]; b = nb[2][2]; end
        SEC_VERT:      begin a = nb[0][1]; b = nb[2][1]; end
        default:       begin a = nb[0][2]; b = nb[2][0]; end
      endcase
      peak    = (a > b) ? a : b;
      centre  = win[1][1].mag;
      last_px = (pr == frame_h - 1) && (pc == frame_w - 1);
      res.mag = (centre < peak) ? 8'd0 : centre;
      res.eor = (pc == frame_w - 1);
      res.eof = last_px;
      expected_pixels.push_back(res);
    end

    // the transaction releasing the last pixel is consumed by the restart
    if (last_px) begin
      restart_frame();
    end else begin
      col_pos++;
      if (col_pos >= frame_w) begin
        col_pos = 0;
        if (row_pos < REG_LIMIT) row_pos++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: register writes, input transactions and output checks, sampled
  // at the rising edge; prediction runs before the check in the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    nms_result_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_FRAME_WIDTH: begin
            frame_w = clamp_dim(pwdata[10:0]);
            restart_frame();
          end
          ADDR_FRAME_HEIGHT: begin
            frame_h = clamp_dim(pwdata[10:0]);
            restart_frame();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_pixel(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected output transaction mag %0d eor %0b eof %0b",
                     $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata !== want.mag || m_axis_tlast !== want.eor ||
              m_axis_tuser !== want.eof) begin
            if (fail_count < 10)
              $display("%0t: mismatch, expected mag %0d eor %0b eof %0b, got %0d %0b %0b",
                       $realtime, want.mag, want.eor, want.eof,
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sink: random tready, or a long hold counted here when a test asks
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: ends the run after too long without any transaction
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, all changing at the falling edge
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // read a register back and compare it with the predictor's copy
  task automatic check_reg(input logic [2:0] addr, input int want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(want)) begin
      if (fail_count < 10)
        $display("%0t: register %0d read, expected %0d, got %0d",
                 $realtime, addr, want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one pixel transaction, with random gaps ahead of it, and return once
  // it has been taken; tvalid stays high into the next item when there is no gap
  task automatic send_item(input logic kind, input logic [7:0] mag,
                           input logic signed [15:0] ang);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ang, mag};
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // random pixel, biased towards ties, extremes and sector edges
  task automatic send_random_item(input int flush_pct);
    logic              kind;
    logic [7:0]        mag;
    logic signed [15:0] ang;
    int                bnd;
    kind = ($urandom_range(99) < flush_pct) ? KIND_FLUSH : KIND_PIXEL;
    case ($urandom_range(3))
      0:       mag = 8'($urandom);
      1:       mag = 8'(100 + $urandom_range(2));  // near ties
      2:       mag = $urandom_range(1) ? 8'hff : 8'h00;
      default: mag = 8'($urandom_range(15));
    endcase
    case ($urandom_range(3))
      0: ang = 16'($urandom);                      // whole code space, out of range too
      1: ang = 16'($urandom_range(51472) - 25736); // -pi .. pi
      default: begin
        case ($urandom_range(7))
          0:       bnd = ANG_P1;
          1:       bnd = ANG_P2;
          2:       bnd = ANG_P3;
          3:       bnd = ANG_P4;
          4:       bnd = ANG_N1;
          5:       bnd = ANG_N2;
          6:       bnd = ANG_N3;
          default: bnd = ANG_N4;
        endcase
        ang = 16'(bnd + int'($urandom_range(4)) - 2);
      end
    endcase
    send_item(kind, mag, ang);
  endtask

  // stop offering, let every expected pixel arrive, then let the pipe settle
  task automatic wait_for_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // send n transactions in whole-frame order, trailing ones mostly flush
  task automatic send_frames(input int n);
    int per_frame, area, i;
    area      = frame_w * frame_h;
    per_frame = area + frame_w + 1;
    for (i = 0; i < n; i++)
      send_random_item(((i % per_frame) >= area) ? 75 : 8);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // two 3x3 frames: both sides of every sector edge, range ends, ties,
  // flush inside a frame and real pixels past the last row
  task automatic test_directed_extremes();
    logic signed [15:0] dir_ang [26] = '{
      16'sd3216, 16'sd3217, 16'sd9650, 16'sd9651, 16'sd16084, 16'sd16085,
      16'sd22518, 16'sd22519, 16'sd25736, 16'sd32767, 16'sh8000, 16'sd0, -16'sd1,
      -16'sd22519, -16'sd22518, -16'sd16085, -16'sd16084, -16'sd9651, -16'sd9650,
      -16'sd3217, -16'sd3216, -16'sd25736, -16'sd1, 16'sd0, 16'sd32767, 16'sh8000};
    logic [7:0] dir_mag [26] = '{
      8'd255, 8'd0, 8'd255, 8'd1, 8'd200, 8'd128, 8'd255, 8'd254, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0,
      8'd7, 8'd7, 8'd7, 8'd255, 8'd7, 8'd0, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255};
    int i;
    // below-range values clamp up to the 3x3 minimum
    write_reg(ADDR_FRAME_WIDTH, 32'd0);
    write_reg(ADDR_FRAME_HEIGHT, 32'd2);
    for (i = 0; i < 26; i++)
      send_item((i == 4 || (i >= 9 && i <= 12)) ? KIND_FLUSH : KIND_PIXEL,
                dir_mag[i], dir_ang[i]);
    wait_for_drain();
  endtask

  // mostly whole frames of random content on random small geometries, with
  // frames cut short by a register write and frames spilling into the next
  task automatic test_random_frames(input int target);
    int sent, n, plan, w, h;
    logic aligned;
    sent    = 0;
    aligned = 1'b0;
    while (sent < target) begin
      wait_for_drain();
      if (!aligned || $urandom_range(3) != 0) begin
        w = $urandom_range(12, 3);
        h = $urandom_range(8, 3);
        if ($urandom_range(9) == 0) w = $urandom_range(2);
        if ($urandom_range(9) == 0) h = $urandom_range(2);
        // upper bits are not held by the 11-bit registers
        if ($urandom_range(1)) begin
          write_reg(ADDR_FRAME_HEIGHT, ($urandom & 32'hffff_f800) | 32'(h));
          write_reg(ADDR_FRAME_WIDTH, ($urandom & 32'hffff_f800) | 32'(w));
        end else begin
          write_reg(ADDR_FRAME_WIDTH, 32'(w));
          write_reg(ADDR_FRAME_HEIGHT, 32'(h));
        end
      end
      n    = frame_w * frame_h + frame_w + 1;
      plan = $urandom_range(99);
      aligned = 1'b1;
      if (plan < 15) begin
        n = $urandom_range(n - 1, 1);
        aligned = 1'b0;
      end else if (plan < 25) begin
        n = n + $urandom_range(frame_w, 1);
        aligned = 1'b0;
      end else if (plan < 45) begin
        n = 2 * n;
      end
      send_frames(n);
      sent += n;
    end
    wait_for_drain();
  endtask

  // sink held off for a long stretch while the source keeps offering, so the
  // block fills up and stalls its input
  task automatic test_output_hold();
    write_reg(ADDR_FRAME_WIDTH, 32'd40);
    write_reg(ADDR_FRAME_HEIGHT, 32'd6);
    hold_request = HOLD_CYCLES;
    send_frames(40 * 6 + 41);
    wait_for_drain();
  endtask

  // widest and tallest geometries, reached through upper clamping and read
  // back, then a short run into the tallest frame
  task automatic test_largest_frames();
    write_reg(ADDR_FRAME_WIDTH, 32'd2047);         // clamps to 1024
    write_reg(ADDR_FRAME_HEIGHT, 32'hffff_f800);   // low bits zero, clamps to 3
    check_reg(ADDR_FRAME_WIDTH, frame_w);
    check_reg(ADDR_FRAME_HEIGHT, frame_h);
    write_reg(ADDR_FRAME_WIDTH, 32'd1);            // clamps to 3
    write_reg(ADDR_FRAME_HEIGHT, 32'd1025);        // clamps to 1024
    check_reg(ADDR_FRAME_WIDTH, frame_w);
    check_reg(ADDR_FRAME_HEIGHT, frame_h);
    send_frames(3 * 8);
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // source seldom idle, sink often stalled
    send_idle_pct = 27;
    recv_idle_pct = 76;
    test_directed_extremes();
    test_random_frames(100);

    // the other way round
    send_idle_pct = 76;
    recv_idle_pct = 27;
    test_random_frames(100);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(100);
    test_output_hold();
    test_largest_frames();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
